### design/plist_pkg.sv
// plist_pkg: widths, command and status codes, and the control/status
// structs shared by the positional list engine modules.
// No dependencies.
package plist_pkg;

  localparam int CMD_W            = 3;
  localparam int POS_W            = 6;
  localparam int WORD_W           = 32;
  localparam int STATUS_W         = 2;
  localparam int COUNT_W          = 7;
  localparam int DEFAULT_CAPACITY = 64;

  // command codes; codes above overwrite only report the count
  localparam logic [CMD_W-1:0] CMD_APPEND    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READ      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_OVERWRITE = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  // how the cursor register is loaded
  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_LAST,
    CUR_NEXT,
    CUR_TGT,
    CUR_INC,
    CUR_DEC
  } cur_op_t;

  typedef enum logic [1:0] {
    WA_TGT,
    WA_UP,
    WA_DN
  } wr_addr_t;

  typedef enum logic {
    WD_ITEM,
    WD_RDATA
  } wr_data_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  typedef struct packed {
    logic                load;
    cur_op_t             cur_op;
    logic                rd_en;
    logic                wr_en;
    wr_addr_t            wr_addr;
    wr_data_t            wr_data;
    cnt_op_t             cnt_op;
    logic                res_load;
    logic [STATUS_W-1:0] res_status;
    logic                res_read;
  } plist_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic             full;
    logic             miss;
    logic             tgt_is_count;
    logic             tgt_is_last;
    logic             cur_is_tgt;
    logic             cur_is_last;
    logic             out_free;
  } plist_stat_t;

endpackage

### design/plist_req_if.sv
// plist_req_if: command channel of the positional list engine.
// Depends on plist_pkg for field widths.
interface plist_req_if;
  logic                           valid;
  logic                           ready;
  logic [plist_pkg::CMD_W-1:0]    command;
  logic [plist_pkg::POS_W-1:0]    position;
  logic [plist_pkg::WORD_W-1:0]   item;

  modport source (output valid, command, position, item, input ready);
  modport sink (input valid, command, position, item, output ready);
endinterface

### design/plist_rsp_if.sv
// plist_rsp_if: result channel of the positional list engine.
// Depends on plist_pkg for field widths.
interface plist_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [plist_pkg::STATUS_W-1:0]  status;
  logic [plist_pkg::WORD_W-1:0]    data;
  logic [plist_pkg::COUNT_W-1:0]   count;

  modport source (output valid, status, data, count, input ready);
  modport sink (input valid, status, data, count, output ready);
endinterface

### design/plist_ctrl.sv
// plist_ctrl: command sequencer of the positional list engine; decodes each
// command and steps the datapath through shifts, writes and the result load.
// Depends on plist_pkg.
module plist_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_ready,
  input  plist_pkg::plist_stat_t stat,
  output plist_pkg::plist_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DECODE   = 3'd1;
  localparam logic [2:0] S_SHIFT_UP = 3'd2;
  localparam logic [2:0] S_PUT      = 3'd3;
  localparam logic [2:0] S_SHIFT_DN = 3'd4;
  localparam logic [2:0] S_DONE     = 3'd5;

  logic [2:0]                     state, state_next;
  logic [plist_pkg::STATUS_W-1:0] res_status, res_status_next;
  logic                           res_read, res_read_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_status <= plist_pkg::ST_OK;
      res_read   <= 1'b0;
    end else begin
      state      <= state_next;
      res_status <= res_status_next;
      res_read   <= res_read_next;
    end
  end

  always_comb begin
    state_next      = state;
    res_status_next = res_status;
    res_read_next   = res_read;
    req_ready       = 1'b0;
    cmd.load        = 1'b0;
    cmd.cur_op      = plist_pkg::CUR_HOLD;
    cmd.rd_en       = 1'b0;
    cmd.wr_en       = 1'b0;
    cmd.wr_addr     = plist_pkg::WA_TGT;
    cmd.wr_data     = plist_pkg::WD_ITEM;
    cmd.cnt_op      = plist_pkg::CNT_HOLD;
    cmd.res_load    = 1'b0;
    cmd.res_status  = res_status;
    cmd.res_read    = res_read;

    unique case (state)
      S_IDLE: begin
        // no transaction is taken while reset is held
        req_ready = !rst;
        if (req_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end

      S_DECODE: begin
        res_status_next = plist_pkg::ST_OK;
        res_read_next   = 1'b0;
        state_next      = S_DONE;
        unique case (stat.op) inside
          plist_pkg::CMD_APPEND, plist_pkg::CMD_INSERT: begin
            if (stat.full) begin
              res_status_next = plist_pkg::ST_FULL;
            end else if (stat.tgt_is_count) begin
              cmd.wr_en  = 1'b1;
              cmd.cnt_op = plist_pkg::CNT_INC;
            end else begin
              // move the tail up, starting from the last entry
              cmd.cur_op = plist_pkg::CUR_LAST;
              cmd.rd_en  = 1'b1;
              state_next = S_SHIFT_UP;
            end
          end
          plist_pkg::CMD_REMOVE: begin
            if (stat.miss) begin
              res_status_next = plist_pkg::ST_NOT_FOUND;
            end else if (stat.tgt_is_last) begin
              cmd.cnt_op = plist_pkg::CNT_DEC;
            end else begin
              cmd.cur_op = plist_pkg::CUR_NEXT;
              cmd.rd_en  = 1'b1;
              state_next = S_SHIFT_DN;
            end
          end
          plist_pkg::CMD_READ: begin
            if (stat.miss) begin
              res_status_next = plist_pkg::ST_NOT_FOUND;
            end else begin
              cmd.cur_op    = plist_pkg::CUR_TGT;
              cmd.rd_en     = 1'b1;
              res_read_next = 1'b1;
            end
          end
          plist_pkg::CMD_OVERWRITE: begin
            if (stat.miss) begin
              res_status_next = plist_pkg::ST_NOT_FOUND;
            end else begin
              cmd.wr_en = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end

      S_SHIFT_UP: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = plist_pkg::WA_UP;
        cmd.wr_data = plist_pkg::WD_RDATA;
        if (stat.cur_is_tgt) begin
          state_next = S_PUT;
        end else begin
          cmd.cur_op = plist_pkg::CUR_DEC;
          cmd.rd_en  = 1'b1;
        end
      end

      S_PUT: begin
        cmd.wr_en  = 1'b1;
        cmd.cnt_op = plist_pkg::CNT_INC;
        state_next = S_DONE;
      end

      S_SHIFT_DN: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_addr = plist_pkg::WA_DN;
        cmd.wr_data = plist_pkg::WD_RDATA;
        if (stat.cur_is_last) begin
          cmd.cnt_op = plist_pkg::CNT_DEC;
          state_next = S_DONE;
        end else begin
          cmd.cur_op = plist_pkg::CUR_INC;
          cmd.rd_en  = 1'b1;
        end
      end

      S_DONE: begin
        if (stat.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### design/plist_dpath.sv
// plist_dpath: entry memory, count, cursor and result register of the
// positional list engine, driven by commands from plist_ctrl.
// Depends on plist_pkg.
module plist_dpath #(
  parameter int CAPACITY = plist_pkg::DEFAULT_CAPACITY
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [plist_pkg::CMD_W-1:0]     command,
  input  logic [plist_pkg::POS_W-1:0]     position,
  input  logic [plist_pkg::WORD_W-1:0]    item,
  input  plist_pkg::plist_cmd_t           cmd,
  output plist_pkg::plist_stat_t          stat,
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output logic [plist_pkg::STATUS_W-1:0]  rsp_status,
  output logic [plist_pkg::WORD_W-1:0]    rsp_data,
  output logic [plist_pkg::COUNT_W-1:0]   rsp_count
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > plist_pkg::POS_W) ? CW : plist_pkg::POS_W;
  localparam int XW   = (CW > plist_pkg::COUNT_W) ? CW : plist_pkg::COUNT_W;

  logic [plist_pkg::WORD_W-1:0] mem [CAPACITY];
  logic [plist_pkg::WORD_W-1:0] rdata;

  logic [plist_pkg::CMD_W-1:0]  op;
  logic [plist_pkg::POS_W-1:0]  pos;
  logic [plist_pkg::WORD_W-1:0] word;
  logic [AW-1:0]                target, target_in;
  logic [AW-1:0]                cursor, cursor_next;
  logic [CW-1:0]                count, count_next;
  logic [AW-1:0]                wr_addr;
  logic [plist_pkg::WORD_W-1:0] wr_data;
  logic [XW-1:0]                count_ext;
  logic                         pos_past_end;

  // insert beyond the end and append both land at the current count
  assign pos_past_end = CMPW'(position) > CMPW'(count);
  assign target_in = ((command == plist_pkg::CMD_APPEND) ||
                      ((command == plist_pkg::CMD_INSERT) && pos_past_end)) ?
                     AW'(count) : AW'(position);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op     <= command;
      pos    <= position;
      word   <= item;
      target <= target_in;
    end
  end

  always_comb begin
    unique case (cmd.cur_op)
      plist_pkg::CUR_HOLD: cursor_next = cursor;
      plist_pkg::CUR_LAST: cursor_next = AW'(count - CW'(1));
      plist_pkg::CUR_NEXT: cursor_next = target + AW'(1);
      plist_pkg::CUR_TGT:  cursor_next = target;
      plist_pkg::CUR_INC:  cursor_next = cursor + AW'(1);
      plist_pkg::CUR_DEC:  cursor_next = cursor - AW'(1);
      default:             cursor_next = cursor;
    endcase
  end

  always_comb begin
    unique case (cmd.wr_addr)
      plist_pkg::WA_TGT: wr_addr = target;
      plist_pkg::WA_UP:  wr_addr = cursor + AW'(1);
      plist_pkg::WA_DN:  wr_addr = cursor - AW'(1);
      default:           wr_addr = target;
    endcase
  end

  assign wr_data = (cmd.wr_data == plist_pkg::WD_ITEM) ? word : rdata;

  always_comb begin
    unique case (cmd.cnt_op)
      plist_pkg::CNT_HOLD: count_next = count;
      plist_pkg::CNT_INC:  count_next = count + CW'(1);
      plist_pkg::CNT_DEC:  count_next = count - CW'(1);
      default:             count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    cursor <= cursor_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // single write port, registered read at the cursor being loaded
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata <= mem[cursor_next];
    end
  end

  assign stat.op           = op;
  assign stat.full         = count == CW'(CAPACITY);
  assign stat.miss         = CMPW'(pos) >= CMPW'(count);
  assign stat.tgt_is_count = CW'(target) == count;
  assign stat.tgt_is_last  = (CW'(target) + CW'(1)) == count;
  assign stat.cur_is_tgt   = cursor == target;
  assign stat.cur_is_last  = (CW'(cursor) + CW'(1)) == count;
  assign stat.out_free     = !rsp_valid || rsp_ready;

  assign count_ext = XW'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.res_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      rsp_status <= cmd.res_status;
      rsp_data   <= cmd.res_read ? rdata : '0;
      rsp_count  <= count_ext[plist_pkg::COUNT_W-1:0];
    end
  end

endmodule

### design/positional_list_engine.sv
// positional_list_engine: top level; ordered list of 32-bit words kept in an
// on-chip memory. Depends on plist_pkg, plist_req_if, plist_rsp_if,
// plist_ctrl and plist_dpath.
//
// Usage: commands arrive on req (command, position, item) with valid/ready;
// each transaction gives exactly one result on rsp (status, data, count).
// Commands: append, insert, remove, read, overwrite, count. Insert and
// remove move the entries behind the position by one place in the memory,
// one entry per cycle through the single write port and registered read.
// A command goes from the accepting state through decode, any shift steps
// and, for an insert that moves entries, the write of the new item, to the
// done state, which loads the result register. An insert or a remove moves
// up to CAPACITY - 1 entries. One command is worked on at a time and the
// next is taken in the cycle after the result is loaded.
// Reset empties the list (count zero); memory contents are not cleared and
// need no clearing pass, since only written entries are ever read.
// A stalled receiver holds the result in the output register; the block
// takes one more command, works it and then waits with req.ready low
// until the output register is free.
module positional_list_engine #(
  parameter int CAPACITY = plist_pkg::DEFAULT_CAPACITY
) (
  input  logic        clk,
  input  logic        rst,
  plist_req_if.sink   req,
  plist_rsp_if.source rsp
);

  plist_pkg::plist_cmd_t  cmd;
  plist_pkg::plist_stat_t stat;

  plist_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  plist_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .command    (req.command),
    .position   (req.position),
    .item       (req.item),
    .cmd        (cmd),
    .stat       (stat),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_data   (rsp.data),
    .rsp_count  (rsp.count)
  );

endmodule
